>>> rtl/core/dhv_pkg.sv
// ----------------------------------------------------------------------------
// dhv_pkg - shared types and constants for the host-name validator
// Status codes, character classes, register indexes and reset values.
// ----------------------------------------------------------------------------
package dhv_pkg;

    localparam int LABEL_W = 7;
    localparam int NAME_W  = 8;
    localparam int CHAR_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [LABEL_W-1:0] MAX_LABEL_RESET = LABEL_W'(63);
    localparam logic [NAME_W-1:0]  MIN_NAME_RESET  = NAME_W'(3);
    localparam logic [NAME_W-1:0]  MAX_NAME_RESET  = NAME_W'(254);

    localparam logic [LABEL_W-1:0] LABEL_SAT = '1;
    localparam logic [NAME_W-1:0]  NAME_SAT  = '1;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LABEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_NAME  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_NAME  = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_FORM    = 2'd1,
        ST_CHAR    = 2'd2,
        ST_NUMERIC = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CLS_ALPHA = 2'd0,   // letter or hyphen
        CLS_DIGIT = 2'd1,
        CLS_DOT   = 2'd2,
        CLS_BAD   = 2'd3
    } char_class_t;

    function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
        char_class_t cls;
        if (c == 8'h2D || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
        begin
            cls = CLS_ALPHA;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            cls = CLS_DIGIT;
        end
        else if (c == 8'h2E)
        begin
            cls = CLS_DOT;
        end
        else
        begin
            cls = CLS_BAD;
        end
        return cls;
    endfunction

endpackage

>>> rtl/core/dns_hostname_validator.sv
// ----------------------------------------------------------------------------
// dns_hostname_validator - streaming dotted host-name checker
// Takes one name character per beat and gives one status beat per name.
// ----------------------------------------------------------------------------
// One character is taken every clock cycle while in_ready is high. The per-name
// counters and flags are updated in the cycle a character beat is accepted; the
// status of a name is loaded into the output register in the cycle its last
// character is accepted and shows on the next cycle. Input stays ready while
// the output register is empty or being drained, so a stalled status beat holds
// up input until it is taken. Throughput is set by the single counter/compare
// update path: one character per cycle unless the status output stalls.
module dns_hostname_validator (
    input  logic                            clk,
    input  logic                            rst_n,
    // character stream
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [dhv_pkg::CHAR_W-1:0]      char_in,
    input  logic                            last,
    // status stream
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    // config write port
    input  logic                            cfg_we,
    input  logic [dhv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dhv_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import dhv_pkg::*;

    logic [LABEL_W-1:0] max_label_reg;
    logic [NAME_W-1:0]  min_name_reg;
    logic [NAME_W-1:0]  max_name_reg;

    logic [LABEL_W-1:0] label_cnt_reg, label_cnt_next;
    logic [NAME_W-1:0]  name_cnt_reg,  name_cnt_next;
    logic               prev_dot_reg,  prev_dot_next;
    logic               digits_reg,    digits_next;
    status_t            first_err_reg, first_err_next;

    logic               out_valid_reg, out_valid_next;
    status_t            status_reg,    status_next;

    char_class_t        cls;
    logic [LABEL_W-1:0] label_inc;
    logic [NAME_W-1:0]  name_inc;
    logic               label_over;
    status_t            err_code;
    logic               accept;
    logic               len_bad;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_label_reg <= MAX_LABEL_RESET;
            min_name_reg  <= MIN_NAME_RESET;
            max_name_reg  <= MAX_NAME_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_LABEL: max_label_reg <= cfg_wdata[LABEL_W-1:0];
                REG_MIN_NAME:  min_name_reg  <= cfg_wdata[NAME_W-1:0];
                REG_MAX_NAME:  max_name_reg  <= cfg_wdata[NAME_W-1:0];
                default:       ;
            endcase
        end
    end

    // per-character classification and counter update
    always_comb
    begin
        cls        = classify(char_in);
        label_inc  = (label_cnt_reg == LABEL_SAT) ? label_cnt_reg
                                                  : label_cnt_reg + LABEL_W'(1);
        name_inc   = (name_cnt_reg == NAME_SAT) ? name_cnt_reg
                                                : name_cnt_reg + NAME_W'(1);
        label_over = label_inc > max_label_reg;

        label_cnt_next = label_cnt_reg;
        prev_dot_next  = prev_dot_reg;
        digits_next    = digits_reg;
        err_code       = ST_VALID;

        case (cls)
            CLS_ALPHA:
            begin
                digits_next    = 1'b0;
                prev_dot_next  = 1'b0;
                label_cnt_next = label_inc;
                if (label_over)
                begin
                    err_code = ST_FORM;
                end
            end
            CLS_DIGIT:
            begin
                prev_dot_next  = 1'b0;
                label_cnt_next = label_inc;
                if (label_over)
                begin
                    err_code = ST_FORM;
                end
            end
            CLS_DOT:
            begin
                if (prev_dot_reg)
                begin
                    err_code = ST_FORM;
                end
                prev_dot_next  = 1'b1;
                label_cnt_next = '0;
            end
            default:
            begin
                err_code = ST_CHAR;
            end
        endcase

        // first error sticks
        first_err_next = (first_err_reg == ST_VALID) ? err_code : first_err_reg;
        name_cnt_next  = name_inc;

        // final verdict, length outranks everything
        len_bad = (name_inc < min_name_reg) || (name_inc > max_name_reg);
        if (len_bad)
        begin
            status_next = ST_FORM;
        end
        else if (first_err_next != ST_VALID)
        begin
            status_next = first_err_next;
        end
        else if (digits_next)
        begin
            status_next = ST_NUMERIC;
        end
        else
        begin
            status_next = ST_VALID;
        end

        // clear per-name state after the last character
        if (last)
        begin
            label_cnt_next = '0;
            name_cnt_next  = '0;
            prev_dot_next  = 1'b1;
            digits_next    = 1'b1;
            first_err_next = ST_VALID;
        end

        // output register handshake
        if (accept && last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // name state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_cnt_reg <= '0;
            name_cnt_reg  <= '0;
            prev_dot_reg  <= 1'b1;
            digits_reg    <= 1'b1;
            first_err_reg <= ST_VALID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                label_cnt_reg <= label_cnt_next;
                name_cnt_reg  <= name_cnt_next;
                prev_dot_reg  <= prev_dot_next;
                digits_reg    <= digits_next;
                first_err_reg <= first_err_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // status payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            status_reg <= status_next;
        end
    end

endmodule

>>> rtl/core/dhv_checker.sv
// ----------------------------------------------------------------------------
// dhv_checker - port-level checks for the host-name validator
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module dhv_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            last,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [1:0]                      status
);
    // a stalled status beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("status beat changed while stalled");

    // empty output register never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // the last character of a name produces a status beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> out_valid)
        else $error("no status after last character");

    // no status appears without a last character
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(in_valid && in_ready && last) |=> !out_valid)
        else $error("status beat without a finished name");

endmodule

bind dns_hostname_validator dhv_checker u_dhv_checker (.*);
